@@ rtl/core/pal_pkg.sv @@
// Shared types and constants for the positional array list block.
// Holds field widths, operation and status codes, and the cell control struct.
// No dependencies.
package pal_pkg;

    // Field widths of the stream items
    localparam int OP_W        = 2;
    localparam int POS_W       = 8;
    localparam int VAL_W       = 32;
    localparam int ST_W        = 2;
    localparam int COUNT_W     = 8;
    localparam int IN_TDATA_W  = 48;
    localparam int OUT_TDATA_W = 48;

    // Default list capacity and read-tree grouping
    localparam int DEPTH_DEF   = 128;
    localparam int GROUP_SIZE  = 16;

    typedef enum logic [OP_W-1:0] {
        OP_INSERT = 2'd0,
        OP_DELETE = 2'd1,
        OP_MODIFY = 2'd2,
        OP_READ   = 2'd3
    } t_op;

    typedef enum logic [ST_W-1:0] {
        ST_OK      = 2'd0,
        ST_FULL    = 2'd1,
        ST_BAD_POS = 2'd2
    } t_status;

    // What every cell does in the current cycle
    typedef enum logic [2:0] {
        ACT_HOLD   = 3'd0,
        ACT_INSERT = 3'd1,
        ACT_DELETE = 3'd2,
        ACT_WRITE  = 3'd3,
        ACT_READ   = 3'd4
    } t_act;

    typedef struct packed {
        t_act              act;
        logic [POS_W-1:0]  pos;
        logic [VAL_W-1:0]  value;
    } t_cell_ctl;

endpackage

@@ rtl/core/pal_cell.sv @@
// One storage cell of the positional array list: holds a single entry.
// Shifts from its left or right neighbor, takes a new value, or drives it for a read.
// Depends on pal_pkg.
module pal_cell
    import pal_pkg::*;
#(
    parameter int INDEX = 0
) (
    input  logic             i_clk,
    input  t_cell_ctl        i_ctl,
    input  logic [VAL_W-1:0] i_left,
    input  logic [VAL_W-1:0] i_right,
    output logic [VAL_W-1:0] o_entry,
    output logic [VAL_W-1:0] o_sel
);

    logic [VAL_W-1:0] r_entry;
    logic [VAL_W-1:0] n_entry;
    logic             w_at;
    logic             w_above;

    // Compare this cell's place with the target position
    assign w_at    = (INDEX == int'(i_ctl.pos));
    assign w_above = (INDEX >  int'(i_ctl.pos));

    // Pick the next entry for this cell
    always_comb begin
        n_entry = r_entry;
        case (i_ctl.act)
            ACT_INSERT: begin
                if (w_at) begin
                    n_entry = i_ctl.value;
                end else if (w_above) begin
                    n_entry = i_left;
                end
            end
            ACT_DELETE: begin
                if (w_at || w_above) begin
                    n_entry = i_right;
                end
            end
            ACT_WRITE: begin
                if (w_at) begin
                    n_entry = i_ctl.value;
                end
            end
            default: begin
                n_entry = r_entry;
            end
        endcase
    end

    // Hold the entry; payload only, no reset
    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

    assign o_entry = r_entry;
    // Drive the entry onto the read tree only when addressed by a read
    assign o_sel   = ((i_ctl.act == ACT_READ) && w_at) ? r_entry : '0;

endmodule

@@ rtl/core/positional_array_list_unit.sv @@
// Top level of the positional array list: stream ports, request decode,
// the row of pal_cell storage cells and a registered read tree.
// Depends on pal_pkg and pal_cell.
//
// Usage:
//   Requests arrive on the s_axis channel, one item per request, with tdata
//   holding op, position and value. Each request gives exactly one result on
//   the m_axis channel with status, read_value and the entry count after the
//   operation. Insert and delete shift every cell above the position (for
//   delete, at or above it) by one place in the same cycle, so all four
//   operations finish in the cycle the item is taken. Throughput is one item
//   per cycle while the receiver keeps up. The result is offered after the
//   two registered levels of the read tree (groups of GROUP_SIZE cells, then
//   the group results) and stays offered until the receiver takes it.
//   Reset clears the count and the pipeline valids and holds s_axis tready
//   low; entries are left as they are, and only written entries can be read.
//   When the receiver stalls, up to two results are held in the pipeline and
//   s_axis tready drops once both stages are full; nothing is lost.
module positional_array_list_unit
    import pal_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_s_axis_tvalid,
    output logic                   o_s_axis_tready,
    input  logic [IN_TDATA_W-1:0]  i_s_axis_tdata,   // op, position, value
    output logic                   o_m_axis_tvalid,
    input  logic                   i_m_axis_tready,
    output logic [OUT_TDATA_W-1:0] o_m_axis_tdata    // status, read_value, count
);

    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int CMP_W  = (CNT_W > POS_W) ? CNT_W : POS_W;
    localparam int NGROUP = (DEPTH + GROUP_SIZE - 1) / GROUP_SIZE;

    // Input field unpacking
    t_op               w_op;
    logic [POS_W-1:0]  w_pos;
    logic [VAL_W-1:0]  w_value;
    logic              w_s_acc;

    assign w_op    = t_op'(i_s_axis_tdata[OP_W-1:0]);
    assign w_pos   = i_s_axis_tdata[OP_W +: POS_W];
    assign w_value = i_s_axis_tdata[OP_W+POS_W +: VAL_W];

    // Pipeline control
    logic r_a_valid;
    logic r_b_valid;
    logic w_b_free;
    logic w_a_move;

    assign w_b_free        = !r_b_valid || i_m_axis_tready;
    assign w_a_move        = r_a_valid && w_b_free;
    assign o_s_axis_tready = i_rst_n && (!r_a_valid || w_b_free);
    assign w_s_acc         = i_s_axis_tvalid && o_s_axis_tready;

    // Count and request decode
    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;
    logic [CMP_W-1:0] w_pos_c;
    logic [CMP_W-1:0] w_cnt_c;
    logic             w_full;
    t_status          w_status;
    t_act             w_act;
    t_cell_ctl        w_ctl;

    assign w_pos_c = CMP_W'(w_pos);
    assign w_cnt_c = CMP_W'(r_count);
    assign w_full  = (w_cnt_c == CMP_W'(DEPTH));

    always_comb begin
        w_status = ST_OK;
        w_act    = ACT_HOLD;
        n_count  = r_count;
        case (w_op)
            OP_INSERT: begin
                if (w_full) begin
                    w_status = ST_FULL;
                end else if (w_pos_c > w_cnt_c) begin
                    w_status = ST_BAD_POS;
                end else begin
                    w_act   = ACT_INSERT;
                    n_count = CNT_W'(r_count + 1'b1);
                end
            end
            OP_DELETE: begin
                if (w_pos_c >= w_cnt_c) begin
                    w_status = ST_BAD_POS;
                end else begin
                    w_act   = ACT_DELETE;
                    n_count = CNT_W'(r_count - 1'b1);
                end
            end
            OP_MODIFY: begin
                if (w_pos_c >= w_cnt_c) begin
                    w_status = ST_BAD_POS;
                end else begin
                    w_act = ACT_WRITE;
                end
            end
            OP_READ: begin
                if (w_pos_c >= w_cnt_c) begin
                    w_status = ST_BAD_POS;
                end else begin
                    w_act = ACT_READ;
                end
            end
            default: begin
                w_status = ST_OK;
            end
        endcase
    end

    // Broadcast control to the row; idle cells hold
    assign w_ctl.act   = w_s_acc ? w_act : ACT_HOLD;
    assign w_ctl.pos   = w_pos;
    assign w_ctl.value = w_value;

    // Row of cells
    logic [VAL_W-1:0] w_entry [DEPTH];
    logic [VAL_W-1:0] w_sel   [DEPTH];

    for (genvar gi = 0; gi < DEPTH; gi++) begin : g_cell
        logic [VAL_W-1:0] w_left;
        logic [VAL_W-1:0] w_right;
        if (gi == 0) begin : g_first
            assign w_left = '0;
        end else begin : g_mid_l
            assign w_left = w_entry[gi-1];
        end
        if (gi == DEPTH - 1) begin : g_last
            assign w_right = w_entry[gi];
        end else begin : g_mid_r
            assign w_right = w_entry[gi+1];
        end
        pal_cell #(
            .INDEX (gi)
        ) u_cell (
            .i_clk   (i_clk),
            .i_ctl   (w_ctl),
            .i_left  (w_left),
            .i_right (w_right),
            .o_entry (w_entry[gi]),
            .o_sel   (w_sel[gi])
        );
    end

    // First tree level: OR each group of cells
    logic [VAL_W-1:0] w_grp [NGROUP];

    always_comb begin
        for (int g = 0; g < NGROUP; g++) begin
            w_grp[g] = '0;
            for (int k = 0; k < GROUP_SIZE; k++) begin
                if (g * GROUP_SIZE + k < DEPTH) begin
                    w_grp[g] = w_grp[g] | w_sel[g * GROUP_SIZE + k];
                end
            end
        end
    end

    // Stage A: status, count and group results
    t_status          r_a_status;
    logic [COUNT_W-1:0] r_a_count;
    logic [VAL_W-1:0] r_a_grp [NGROUP];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count   <= '0;
            r_a_valid <= 1'b0;
        end else begin
            if (w_s_acc) begin
                r_count   <= n_count;
                r_a_valid <= 1'b1;
            end else if (w_a_move) begin
                r_a_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_s_acc) begin
            r_a_status <= w_status;
            r_a_count  <= COUNT_W'(n_count);
            for (int g = 0; g < NGROUP; g++) begin
                r_a_grp[g] <= w_grp[g];
            end
        end
    end

    // Second tree level: OR the group results
    logic [VAL_W-1:0] w_rd;

    always_comb begin
        w_rd = '0;
        for (int g = 0; g < NGROUP; g++) begin
            w_rd = w_rd | r_a_grp[g];
        end
    end

    // Stage B: output register
    t_status            r_b_status;
    logic [VAL_W-1:0]   r_b_rd;
    logic [COUNT_W-1:0] r_b_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
        end else begin
            if (w_a_move) begin
                r_b_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_b_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_a_move) begin
            r_b_status <= r_a_status;
            r_b_rd     <= w_rd;
            r_b_count  <= r_a_count;
        end
    end

    assign o_m_axis_tvalid = r_b_valid;
    assign o_m_axis_tdata  = {{(OUT_TDATA_W - ST_W - VAL_W - COUNT_W){1'b0}},
                              r_b_count, r_b_rd, r_b_status};

    // Checks
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        CMP_W'(r_count) <= CMP_W'(DEPTH))
        else $error("entry count above capacity");

    a_insert_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_s_acc && (w_act == ACT_INSERT)) |=> (r_count == CNT_W'($past(r_count) + 1'b1)))
        else $error("insert did not grow the count");

    a_full_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_s_acc && (w_op == OP_INSERT) && w_full)
            |=> ((r_a_status == ST_FULL) && (r_count == $past(r_count))))
        else $error("insert into a full list changed state");

    a_rd_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_b_valid && (r_b_status != ST_OK)) |-> (r_b_rd == '0))
        else $error("failed request returned nonzero read data");

endmodule

@@ tb/sv/tb_positional_array_list_unit.sv @@
// Self-checking testbench for positional_array_list_unit: directed table, then random
// list traffic under several idle and stall mixes, checked against an in-bench list model.
// Depends on pal_pkg and the RTL of the block.
module tb_positional_array_list_unit import pal_pkg::*; ;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LIST_DEPTH   = DEPTH_DEF;
    localparam int IDLE_LIMIT   = 2000;
    localparam int HOLD_CYCLES  = 40;
    localparam int PHASE_ITEMS  = 113;
    localparam int TAIL_CYCLES  = 10;
    localparam int DIR_ROWS     = 25;

    typedef struct {
        t_status            status;
        logic [VAL_W-1:0]   rd;
        logic [COUNT_W-1:0] count;
    } t_answer;

    typedef struct {
        t_op              op;
        logic [POS_W-1:0] pos;
        logic [VAL_W-1:0] val;
        bit               typed;
        t_answer          ans;
    } t_dir_row;

    logic                   clk      = 1'b0;
    logic                   rst_n    = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic [IN_TDATA_W-1:0]  s_tdata  = '0;
    logic                   m_tready = 1'b0;
    logic                   o_s_tready;
    logic                   o_m_tvalid;
    logic [OUT_TDATA_W-1:0] o_m_tdata;

    // List model state
    logic [VAL_W-1:0] list_mem [LIST_DEPTH];
    int               list_len  = 0;
    int               peak_len  = 0;

    t_answer  pending_results [$];
    t_dir_row dir_rows [DIR_ROWS];

    int send_idle_pct = 0;
    int stall_pct     = 0;
    bit hold_req      = 1'b0;
    int n_accepted    = 0;
    int n_results     = 0;
    int n_errors      = 0;
    int n_full        = 0;
    int n_bad_pos     = 0;
    int idle_cycles   = 0;

    positional_array_list_unit dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (o_s_tready),
        .i_s_axis_tdata  (s_tdata),      // op, position, value
        .o_m_axis_tvalid (o_m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (o_m_tdata)     // status, read_value, count
    );

    initial begin
        forever begin
            #4 clk = ~clk;
        end
    end

    // Apply one request to the list model and return the answer it gives
    function automatic t_answer list_apply(t_op op, int pos, logic [VAL_W-1:0] val);
        t_answer a;
        int      i;
        a.status = ST_OK;
        a.rd     = '0;
        case (op)
            OP_INSERT: begin
                // a full list is reported before the position is looked at
                if (list_len >= LIST_DEPTH) begin
                    a.status = ST_FULL;
                end else if (pos > list_len) begin
                    a.status = ST_BAD_POS;
                end else begin
                    for (i = list_len; i > pos; i--) list_mem[i] = list_mem[i-1];
                    list_mem[pos] = val;
                    list_len++;
                end
            end
            OP_DELETE: begin
                if (pos >= list_len) begin
                    a.status = ST_BAD_POS;
                end else begin
                    for (i = pos; i + 1 < list_len; i++) list_mem[i] = list_mem[i+1];
                    list_len--;
                end
            end
            OP_MODIFY: begin
                if (pos >= list_len) a.status = ST_BAD_POS;
                else list_mem[pos] = val;
            end
            default: begin
                if (pos >= list_len) a.status = ST_BAD_POS;
                else a.rd = list_mem[pos];
            end
        endcase
        if (list_len > peak_len) peak_len = list_len;
        a.count = list_len[COUNT_W-1:0];
        return a;
    endfunction

    // Offer one request, hold it until taken, then log its expected answer
    task automatic offer_request(input t_op op, input logic [POS_W-1:0] pos,
                                 input logic [VAL_W-1:0] val, input bit typed,
                                 input t_answer typed_ans);
        t_answer a;
        @(negedge clk);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {{(IN_TDATA_W-OP_W-POS_W-VAL_W){1'b0}}, val, pos, op};
        do @(posedge clk); while (!o_s_tready);
        a = list_apply(op, int'(pos), val);
        if (typed) a = typed_ans;
        pending_results.push_back(a);
        n_accepted++;
    endtask

    // Drop valid and wait until every outstanding answer has come back
    task automatic drain_results();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge clk);
    endtask

    // Receiver: random stalls, plus a long hold-off on request
    initial begin
        forever begin
            @(negedge clk);
            if (hold_req) begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(negedge clk);
                hold_req = 1'b0;
            end else begin
                m_tready <= ($urandom_range(0, 99) >= stall_pct);
            end
        end
    end

    // Check each answer against the oldest expectation
    always @(posedge clk) begin
        t_answer          exp_a;
        t_status          got_st;
        logic [VAL_W-1:0] got_rd;
        logic [COUNT_W-1:0] got_cnt;
        got_st  = t_status'(o_m_tdata[ST_W-1:0]);
        got_rd  = o_m_tdata[ST_W +: VAL_W];
        got_cnt = o_m_tdata[ST_W+VAL_W +: COUNT_W];
        if (rst_n && o_m_tvalid && m_tready) begin
            if (pending_results.size() == 0) begin
                $display("%0t: answer with none expected, tdata %h", $time, o_m_tdata);
                n_errors++;
            end else begin
                exp_a = pending_results.pop_front();
                n_results++;
                if (exp_a.status == ST_FULL) n_full++;
                if (exp_a.status == ST_BAD_POS) n_bad_pos++;
                if (got_st != exp_a.status) begin
                    $display("%0t: status expected %0d, got %0d", $time, exp_a.status, got_st);
                    n_errors++;
                end
                if (got_rd != exp_a.rd) begin
                    $display("%0t: read_value expected %h, got %h", $time, exp_a.rd, got_rd);
                    n_errors++;
                end
                if (got_cnt != exp_a.count) begin
                    $display("%0t: count expected %0d, got %0d", $time, exp_a.count, got_cnt);
                    n_errors++;
                end
            end
        end
    end

    // Watchdog: end the run when no item moves for too long
    always @(posedge clk) begin
        if (!rst_n || (s_tvalid && o_s_tready) || (o_m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("%0t: no item moved for %0d cycles", $time, IDLE_LIMIT);
            $display("status: fail");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        t_answer          none;
        t_op              op;
        logic [POS_W-1:0] pos;
        bit               grow;
        int               r;
        int               ph;
        int               k;

        none = '{ST_OK, '0, '0};
        grow = 1'b1;

        // Directed rows: empty-list errors, extreme values, both ends, bad positions
        dir_rows = '{
            '{OP_READ,   8'd0,   32'h0,        1'b1, '{ST_BAD_POS, 32'h0, 8'd0}},
            '{OP_DELETE, 8'd0,   32'h0,        1'b1, '{ST_BAD_POS, 32'h0, 8'd0}},
            '{OP_MODIFY, 8'd0,   32'h1234,     1'b1, '{ST_BAD_POS, 32'h0, 8'd0}},
            '{OP_INSERT, 8'd1,   32'h1,        1'b1, '{ST_BAD_POS, 32'h0, 8'd0}},
            '{OP_INSERT, 8'd0,   32'h7FFFFFFF, 1'b1, '{ST_OK,      32'h0, 8'd1}},
            '{OP_INSERT, 8'd0,   32'h80000000, 1'b1, '{ST_OK,      32'h0, 8'd2}},
            '{OP_READ,   8'd0,   32'h0,        1'b1, '{ST_OK, 32'h80000000, 8'd2}},
            '{OP_READ,   8'd1,   32'h0,        1'b1, '{ST_OK, 32'h7FFFFFFF, 8'd2}},
            '{OP_READ,   8'd2,   32'h0,        1'b1, '{ST_BAD_POS, 32'h0, 8'd2}},
            '{OP_INSERT, 8'd2,   32'hFFFFFFFF, 1'b1, '{ST_OK,      32'h0, 8'd3}},
            '{OP_INSERT, 8'd1,   32'h00000001, 1'b0, none},
            '{OP_READ,   8'd1,   32'h0,        1'b0, none},
            '{OP_MODIFY, 8'd3,   32'h5555AAAA, 1'b0, none},
            '{OP_READ,   8'd3,   32'h0,        1'b0, none},
            '{OP_MODIFY, 8'd4,   32'h0,        1'b1, '{ST_BAD_POS, 32'h0, 8'd4}},
            '{OP_DELETE, 8'd0,   32'h0,        1'b0, none},
            '{OP_READ,   8'd0,   32'h0,        1'b0, none},
            '{OP_DELETE, 8'd2,   32'h0,        1'b0, none},
            '{OP_DELETE, 8'd2,   32'h0,        1'b1, '{ST_BAD_POS, 32'h0, 8'd2}},
            '{OP_INSERT, 8'd255, 32'hAAAA5555, 1'b1, '{ST_BAD_POS, 32'h0, 8'd2}},
            '{OP_READ,   8'd255, 32'h0,        1'b1, '{ST_BAD_POS, 32'h0, 8'd2}},
            '{OP_READ,   8'd128, 32'h0,        1'b1, '{ST_BAD_POS, 32'h0, 8'd2}},
            '{OP_DELETE, 8'd1,   32'h0,        1'b0, none},
            '{OP_DELETE, 8'd0,   32'h0,        1'b0, none},
            '{OP_READ,   8'd0,   32'h0,        1'b1, '{ST_BAD_POS, 32'h0, 8'd0}}
        };

        repeat (9) @(negedge clk);
        rst_n <= 1'b1;

        foreach (dir_rows[i]) begin
            offer_request(dir_rows[i].op, dir_rows[i].pos, dir_rows[i].val,
                          dir_rows[i].typed, dir_rows[i].ans);
        end

        // Random traffic: grow toward full, then shrink toward empty, repeat.
        // Phases: no idling but one long receiver hold-off, sender idle, receiver stalls, both idle.
        for (ph = 0; ph < 4; ph++) begin
            drain_results();
            case (ph)
                0:       begin send_idle_pct = 0;  stall_pct = 0;  end
                1:       begin send_idle_pct = 74; stall_pct = 0;  end
                2:       begin send_idle_pct = 0;  stall_pct = 74; end
                default: begin send_idle_pct = 27; stall_pct = 27; end
            endcase
            for (k = 0; k < PHASE_ITEMS; k++) begin
                if (ph == 0 && k == 40) hold_req = 1'b1;
                if (list_len == LIST_DEPTH) grow = 1'b0;
                if (list_len == 0) grow = 1'b1;
                r = $urandom_range(0, 99);
                if (grow) begin
                    op = (r < 85) ? OP_INSERT : (r < 88) ? OP_DELETE :
                         (r < 94) ? OP_MODIFY : OP_READ;
                end else if (list_len == LIST_DEPTH && r < 40) begin
                    op = OP_INSERT;
                end else begin
                    op = (r < 80) ? OP_DELETE : (r < 85) ? OP_INSERT :
                         (r < 92) ? OP_MODIFY : OP_READ;
                end
                // mostly legal positions, some anywhere in the 8-bit range
                if ($urandom_range(0, 9) == 0) begin
                    pos = POS_W'($urandom_range(0, 255));
                end else if (op == OP_INSERT) begin
                    pos = POS_W'($urandom_range(0, list_len));
                end else if (list_len == 0) begin
                    pos = POS_W'($urandom_range(0, 255));
                end else begin
                    pos = POS_W'($urandom_range(0, list_len - 1));
                end
                offer_request(op, pos, $urandom, 1'b0, none);
            end
        end

        drain_results();
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("run: %0d requests, %0d answers, list peaked at %0d of %0d entries",
                 n_accepted, n_results, peak_len, LIST_DEPTH);
        $display("run: %0d inserts into a full list, %0d bad positions, %0d mismatches",
                 n_full, n_bad_pos, n_errors);
        if (n_errors == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

@@ positional_array_list_unit.f @@
rtl/core/pal_pkg.sv
rtl/core/pal_cell.sv
rtl/core/positional_array_list_unit.sv
tb/sv/tb_positional_array_list_unit.sv
